@@ hdl/tvbb_pkg.sv @@
package tvbb_pkg;

  // Coordinate width default and the fixed coefficient format
  localparam int COORD_WIDTH_DEF = 32;
  localparam int COEF_WIDTH      = 32;
  localparam int FRAC_BITS       = 16;
  localparam int CFG_WIDTH       = 64;
  localparam int CFG_IDX_WIDTH   = 3;

  // Register indexes of the configuration port
  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    REG_ROW0_A = 3'd0,
    REG_ROW0_B = 3'd1,
    REG_ROW1_A = 3'd2,
    REG_ROW1_B = 3'd3,
    REG_ROW2_A = 3'd4,
    REG_ROW2_B = 3'd5
  } cfg_idx_t;

  // Identity transform after reset
  localparam logic [CFG_WIDTH-1:0] ROW0_A_RST = 64'h0000_0000_0001_0000;
  localparam logic [CFG_WIDTH-1:0] ROW0_B_RST = 64'h0000_0000_0000_0000;
  localparam logic [CFG_WIDTH-1:0] ROW1_A_RST = 64'h0001_0000_0000_0000;
  localparam logic [CFG_WIDTH-1:0] ROW1_B_RST = 64'h0000_0000_0000_0000;
  localparam logic [CFG_WIDTH-1:0] ROW2_A_RST = 64'h0000_0000_0000_0000;
  localparam logic [CFG_WIDTH-1:0] ROW2_B_RST = 64'h0000_0000_0001_0000;

  // Load enables of the two arithmetic stages inside a row unit
  typedef struct packed {
    logic mul_en;
    logic sum_en;
  } tvbb_stage_en_t;

endpackage

@@ hdl/tvbb_row.sv @@
module tvbb_row #(
  parameter int COORD_WIDTH = tvbb_pkg::COORD_WIDTH_DEF
) (
  input  logic                              clk,
  input  tvbb_pkg::tvbb_stage_en_t          stage_en,
  input  logic signed [COORD_WIDTH-1:0]     pos_x,
  input  logic signed [COORD_WIDTH-1:0]     pos_y,
  input  logic signed [COORD_WIDTH-1:0]     pos_z,
  input  logic [tvbb_pkg::CFG_WIDTH-1:0]    coef_a,
  input  logic [tvbb_pkg::CFG_WIDTH-1:0]    coef_b,
  output logic signed [COORD_WIDTH-1:0]     coord_r
);

  localparam int CFW = tvbb_pkg::COEF_WIDTH;
  localparam int FB  = tvbb_pkg::FRAC_BITS;
  localparam int PW  = COORD_WIDTH + CFW;   // exact product width
  localparam int SW  = PW + 2;              // sum of three products and offset
  localparam int RW  = SW - FB;             // after dropping fraction bits

  logic signed [CFW-1:0] cx, cy, cz, ct;
  logic signed [PW-1:0]  px_nxt, py_nxt, pz_nxt;
  logic signed [PW-1:0]  px_r, py_r, pz_r;
  logic signed [SW-1:0]  sum;
  logic signed [SW-1:0]  ofs;
  logic signed [RW-1:0]  rnd;
  logic                  fits;
  logic signed [COORD_WIDTH-1:0] coord_nxt;

  assign cx = signed'(coef_a[CFW-1:0]);
  assign cy = signed'(coef_a[2*CFW-1:CFW]);
  assign cz = signed'(coef_b[CFW-1:0]);
  assign ct = signed'(coef_b[2*CFW-1:CFW]);

  // Stage A: the three Q32.32 products
  assign px_nxt = PW'(pos_x) * PW'(cx);
  assign py_nxt = PW'(pos_y) * PW'(cy);
  assign pz_nxt = PW'(pos_z) * PW'(cz);

  always_ff @(posedge clk) begin
    if (stage_en.mul_en) begin
      px_r <= px_nxt;
      py_r <= py_nxt;
      pz_r <= pz_nxt;
    end
  end

  // Stage B: add translation and half an LSB, drop fraction, saturate
  always_comb begin
    ofs  = (SW'(ct) <<< FB) + SW'(1 <<< (FB - 1));
    sum  = SW'(px_r) + SW'(py_r) + SW'(pz_r) + ofs;
    rnd  = RW'(sum >>> FB);
    fits = (rnd[RW-1:COORD_WIDTH-1] == '0) || (rnd[RW-1:COORD_WIDTH-1] == '1);
    if (fits) begin
      coord_nxt = rnd[COORD_WIDTH-1:0];
    end else if (rnd[RW-1]) begin
      coord_nxt = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    end else begin
      coord_nxt = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en.sum_en) begin
      coord_r <= coord_nxt;
    end
  end

endmodule

@@ hdl/transformed_vertex_bounding_box_top.sv @@
// Channel | Direction | Handshake              | Content
// in_     | sink      | in_tvalid / in_tready  | tdata: pos_x, pos_y, pos_z; tlast: last_vertex
// out_    | source    | out_tvalid / out_tready| tdata: box min x,y,z then max x,y,z
// cfg_    | sink      | cfg_valid / cfg_ready  | cfg_index, cfg_data (one 64-bit register)
//
// One vertex per cycle is accepted while in_tready is high. Four registers
// (input, products, rounded coordinate, output) lie between the acceptance
// of the last vertex of a set and the rise of out_tvalid.
// Synchronous active-low reset loads the identity transform, empties the
// pipeline and clears the running box. cfg_ready is always high.
// A stalled box only holds back a later last vertex at the box stage;
// ordinary vertices keep flowing into the running box meanwhile.
module transformed_vertex_bounding_box_top #(
  parameter int COORD_WIDTH = tvbb_pkg::COORD_WIDTH_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  // in_tdata: pos_x, pos_y, pos_z from the lowest bit up, zero padded
  input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]         in_tdata,
  input  logic                                       in_tlast,
  input  logic                                       in_tvalid,
  output logic                                       in_tready,
  // out_tdata: box_min_x, box_min_y, box_min_z, box_max_x, box_max_y,
  // box_max_z from the lowest bit up, zero padded
  output logic [((6*COORD_WIDTH+7)/8)*8-1:0]         out_tdata,
  output logic                                       out_tvalid,
  input  logic                                       out_tready,
  input  logic                                       cfg_valid,
  output logic                                       cfg_ready,
  input  logic [tvbb_pkg::CFG_IDX_WIDTH-1:0]         cfg_index,
  input  logic [tvbb_pkg::CFG_WIDTH-1:0]             cfg_data
);

  localparam int CW    = COORD_WIDTH;
  localparam int OUT_W = ((6*COORD_WIDTH+7)/8)*8;
  localparam logic signed [CW-1:0] POS_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] NEG_MAX = {1'b1, {(CW-1){1'b0}}};

  // Configuration registers
  logic [tvbb_pkg::CFG_WIDTH-1:0] row0_a_r, row0_b_r, row1_a_r, row1_b_r;
  logic [tvbb_pkg::CFG_WIDTH-1:0] row2_a_r, row2_b_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row0_a_r <= tvbb_pkg::ROW0_A_RST;
      row0_b_r <= tvbb_pkg::ROW0_B_RST;
      row1_a_r <= tvbb_pkg::ROW1_A_RST;
      row1_b_r <= tvbb_pkg::ROW1_B_RST;
      row2_a_r <= tvbb_pkg::ROW2_A_RST;
      row2_b_r <= tvbb_pkg::ROW2_B_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (tvbb_pkg::cfg_idx_t'(cfg_index))
        tvbb_pkg::REG_ROW0_A: row0_a_r <= cfg_data;
        tvbb_pkg::REG_ROW0_B: row0_b_r <= cfg_data;
        tvbb_pkg::REG_ROW1_A: row1_a_r <= cfg_data;
        tvbb_pkg::REG_ROW1_B: row1_b_r <= cfg_data;
        tvbb_pkg::REG_ROW2_A: row2_a_r <= cfg_data;
        tvbb_pkg::REG_ROW2_B: row2_b_r <= cfg_data;
        default: ; // drop writes to unused indexes
      endcase
    end
  end

  // Pipeline flow control: a stage advances when the one after it is
  // empty or advancing too. Only a last vertex waits on the output register.
  logic v1_r, v2_r, v3_r;
  logic last1_r, last2_r, last3_r;
  logic go1, go2, go3, free1, free2, free3;
  logic emit;
  tvbb_pkg::tvbb_stage_en_t stage_en;

  assign go3   = v3_r && (!last3_r || !out_tvalid || out_tready);
  assign free3 = !v3_r || go3;
  assign go2   = v2_r && free3;
  assign free2 = !v2_r || go2;
  assign go1   = v1_r && free2;
  assign free1 = !v1_r || go1;
  assign emit  = go3 && last3_r;

  assign in_tready       = free1;
  assign stage_en.mul_en = go1;
  assign stage_en.sum_en = go2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (free1) v1_r <= in_tvalid;
      if (free2) v2_r <= v1_r;
      if (free3) v3_r <= v2_r;
    end
  end

  // Input register
  logic signed [CW-1:0] x1_r, y1_r, z1_r;

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      x1_r    <= signed'(in_tdata[CW-1:0]);
      y1_r    <= signed'(in_tdata[2*CW-1:CW]);
      z1_r    <= signed'(in_tdata[3*CW-1:2*CW]);
      last1_r <= in_tlast;
    end
    if (go1) last2_r <= last1_r;
    if (go2) last3_r <= last2_r;
  end

  // One row unit per output axis
  logic signed [CW-1:0] tx, ty, tz;

  tvbb_row #(.COORD_WIDTH(CW)) u_row_x (
    .clk(clk), .stage_en(stage_en), .pos_x(x1_r), .pos_y(y1_r), .pos_z(z1_r),
    .coef_a(row0_a_r), .coef_b(row0_b_r), .coord_r(tx)
  );

  tvbb_row #(.COORD_WIDTH(CW)) u_row_y (
    .clk(clk), .stage_en(stage_en), .pos_x(x1_r), .pos_y(y1_r), .pos_z(z1_r),
    .coef_a(row1_a_r), .coef_b(row1_b_r), .coord_r(ty)
  );

  tvbb_row #(.COORD_WIDTH(CW)) u_row_z (
    .clk(clk), .stage_en(stage_en), .pos_x(x1_r), .pos_y(y1_r), .pos_z(z1_r),
    .coef_a(row2_a_r), .coef_b(row2_b_r), .coord_r(tz)
  );

  // Running box, including the vertex now in the box stage
  logic signed [CW-1:0] min_x_r, min_y_r, min_z_r, max_x_r, max_y_r, max_z_r;
  logic signed [CW-1:0] min_x_nxt, min_y_nxt, min_z_nxt;
  logic signed [CW-1:0] max_x_nxt, max_y_nxt, max_z_nxt;
  logic signed [CW-1:0] bmin_x_r, bmin_y_r, bmin_z_r, bmax_x_r, bmax_y_r, bmax_z_r;
  logic out_valid_r;

  assign min_x_nxt = (tx < min_x_r) ? tx : min_x_r;
  assign min_y_nxt = (ty < min_y_r) ? ty : min_y_r;
  assign min_z_nxt = (tz < min_z_r) ? tz : min_z_r;
  assign max_x_nxt = (tx > max_x_r) ? tx : max_x_r;
  assign max_y_nxt = (ty > max_y_r) ? ty : max_y_r;
  assign max_z_nxt = (tz > max_z_r) ? tz : max_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_x_r <= POS_MAX;
      min_y_r <= POS_MAX;
      min_z_r <= POS_MAX;
      max_x_r <= NEG_MAX;
      max_y_r <= NEG_MAX;
      max_z_r <= NEG_MAX;
    end else if (emit) begin
      // restart the box for the next set
      min_x_r <= POS_MAX;
      min_y_r <= POS_MAX;
      min_z_r <= POS_MAX;
      max_x_r <= NEG_MAX;
      max_y_r <= NEG_MAX;
      max_z_r <= NEG_MAX;
    end else if (go3) begin
      min_x_r <= min_x_nxt;
      min_y_r <= min_y_nxt;
      min_z_r <= min_z_nxt;
      max_x_r <= max_x_nxt;
      max_y_r <= max_y_nxt;
      max_z_r <= max_z_nxt;
    end
  end

  // Output register: load on a last vertex, hold until the transaction completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      bmin_x_r <= min_x_nxt;
      bmin_y_r <= min_y_nxt;
      bmin_z_r <= min_z_nxt;
      bmax_x_r <= max_x_nxt;
      bmax_y_r <= max_y_nxt;
      bmax_z_r <= max_z_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'({bmax_z_r, bmax_y_r, bmax_x_r, bmin_z_r, bmin_y_r, bmin_x_r});

  // A box only appears after a last vertex left the box stage
  a_box_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(go3 && last3_r))
    else $error("box appeared without a last vertex");

  // The running box restarts right after a box is emitted
  a_box_restart: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> (min_x_r == POS_MAX) && (max_z_r == NEG_MAX))
    else $error("running box not restarted");

  // Once an ordinary vertex is counted, the running extent is not inverted
  a_run_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    (go3 && !last3_r) |=> (min_x_r <= max_x_r) && (min_y_r <= max_y_r)
                          && (min_z_r <= max_z_r))
    else $error("running box inverted");

  // An emitted box always holds at least one point
  a_box_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (bmin_x_r <= bmax_x_r) && (bmin_y_r <= bmax_y_r)
                    && (bmin_z_r <= bmax_z_r))
    else $error("emitted box inverted");

endmodule

@@ tb/sv/transformed_vertex_bounding_box_top_test.sv @@
`timescale 1ns / 1ps

module transformed_vertex_bounding_box_top_test;

  localparam int CW         = tvbb_pkg::COORD_WIDTH_DEF;
  localparam int PIPE_DEPTH = 4;    // input, products, rounding, box register
  localparam int PHASES     = 8;
  localparam int PHASE_ITEMS = 200;
  localparam int MAX_SET_LEN = 12;
  localparam int MAX_IDLE    = 10;
  localparam int MAX_REPORTS = 40;

  // Register indexes past the last register; writes to them must be dropped
  localparam logic [tvbb_pkg::CFG_IDX_WIDTH-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [tvbb_pkg::CFG_IDX_WIDTH-1:0] REG_SPARE_HI = 3'd7;

  // Coefficient styles used to build a transform
  localparam int COEF_MODERATE = 0;  // within +/-4.0
  localparam int COEF_FULL     = 1;  // any 32-bit pattern
  localparam int COEF_EXTREME  = 2;  // zero, -2^-16, most negative, most positive
  localparam int COEF_UNIT     = 3;  // -1.0, 0 or +1.0

  localparam logic [tvbb_pkg::COEF_WIDTH-1:0] Q_ONE     = 32'h0001_0000;
  localparam logic [tvbb_pkg::COEF_WIDTH-1:0] Q_NEG_ONE = 32'hFFFF_0000;
  localparam logic [tvbb_pkg::COEF_WIDTH-1:0] Q_LSB     = 32'h0000_0001;
  localparam logic [tvbb_pkg::COEF_WIDTH-1:0] Q_NEG_LSB = 32'hFFFF_FFFF;
  localparam logic [tvbb_pkg::COEF_WIDTH-1:0] Q_MAX     = 32'h7FFF_FFFF;
  localparam logic [tvbb_pkg::COEF_WIDTH-1:0] Q_MIN     = 32'h8000_0000;

  typedef logic signed [CW-1:0] coord_t;

  // Field order matches out_tdata from the highest bit down
  typedef struct packed {
    coord_t max_z;
    coord_t max_y;
    coord_t max_x;
    coord_t min_z;
    coord_t min_y;
    coord_t min_x;
  } box_t;

  localparam coord_t COORD_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [127:0] SAT_HI = (128'sd1 <<< (CW-1)) - 128'sd1;
  localparam logic signed [127:0] SAT_LO = -(128'sd1 <<< (CW-1));

  logic                                  clk;
  logic                                  rst_n;
  logic [((3*CW+7)/8)*8-1:0]             in_tdata;    // pos_x, pos_y, pos_z
  logic                                  in_tlast;    // last_vertex
  logic                                  in_tvalid;
  logic                                  in_tready;
  logic [((6*CW+7)/8)*8-1:0]             out_tdata;   // min x,y,z then max x,y,z
  logic                                  out_tvalid;
  logic                                  out_tready;
  logic                                  cfg_valid;
  logic                                  cfg_ready;
  logic [tvbb_pkg::CFG_IDX_WIDTH-1:0]    cfg_index;
  logic [tvbb_pkg::CFG_WIDTH-1:0]        cfg_data;

  // Predictor copy of the transform rows and the running box
  logic [tvbb_pkg::CFG_WIDTH-1:0] row_coef_a [3];
  logic [tvbb_pkg::CFG_WIDTH-1:0] row_coef_b [3];
  coord_t                         box_lo [3];
  coord_t                         box_hi [3];

  box_t pending_boxes [$];

  int gap_max   = MAX_IDLE;
  int stall_max = MAX_IDLE;
  int fail_count;
  int vertices_sent;
  int boxes_checked;
  int reg_writes;

  transformed_vertex_bounding_box_top #(
    .COORD_WIDTH (CW)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // One row of the affine transform: exact sum of the three products and the
  // translation (w = 1), rounded half up to Q16.16, then clamped to the
  // coordinate range.
  function automatic coord_t transform_axis(input logic [tvbb_pkg::CFG_WIDTH-1:0] ra,
                                            input logic [tvbb_pkg::CFG_WIDTH-1:0] rb,
                                            input coord_t x, input coord_t y,
                                            input coord_t z);
    logic signed [tvbb_pkg::COEF_WIDTH-1:0]    cx, cy, cz, tr;
    logic signed [CW+tvbb_pkg::COEF_WIDTH-1:0] px, py, pz;
    logic signed [127:0]                       acc;
    logic signed [127:0]                       tr_w;
    cx   = ra[tvbb_pkg::COEF_WIDTH-1:0];
    cy   = ra[tvbb_pkg::CFG_WIDTH-1:tvbb_pkg::COEF_WIDTH];
    cz   = rb[tvbb_pkg::COEF_WIDTH-1:0];
    tr   = rb[tvbb_pkg::CFG_WIDTH-1:tvbb_pkg::COEF_WIDTH];
    px   = x * cx;
    py   = y * cy;
    pz   = z * cz;
    tr_w = tr;
    acc  = px;
    acc  = acc + py;
    acc  = acc + pz;
    acc  = acc + (tr_w <<< tvbb_pkg::FRAC_BITS);
    acc  = acc + (128'sd1 <<< (tvbb_pkg::FRAC_BITS-1));
    acc  = acc >>> tvbb_pkg::FRAC_BITS;
    if (acc > SAT_HI) return COORD_MAX;
    if (acc < SAT_LO) return COORD_MIN;
    return acc[CW-1:0];
  endfunction

  task automatic clear_running_box();
    for (int i = 0; i < 3; i++) begin
      box_lo[i] = COORD_MAX;
      box_hi[i] = COORD_MIN;
    end
  endtask

  task automatic load_identity();
    row_coef_a[0] = tvbb_pkg::ROW0_A_RST;
    row_coef_b[0] = tvbb_pkg::ROW0_B_RST;
    row_coef_a[1] = tvbb_pkg::ROW1_A_RST;
    row_coef_b[1] = tvbb_pkg::ROW1_B_RST;
    row_coef_a[2] = tvbb_pkg::ROW2_A_RST;
    row_coef_b[2] = tvbb_pkg::ROW2_B_RST;
  endtask

  // Fold one accepted vertex into the running box; close the box on the last
  // vertex of a set and queue it for the checker.
  task automatic accumulate_vertex(input coord_t x, input coord_t y, input coord_t z,
                                   input logic last);
    coord_t t [3];
    box_t   b;
    for (int i = 0; i < 3; i++) begin
      t[i] = transform_axis(row_coef_a[i], row_coef_b[i], x, y, z);
      if (t[i] < box_lo[i]) box_lo[i] = t[i];
      if (t[i] > box_hi[i]) box_hi[i] = t[i];
    end
    if (last) begin
      b.min_x = box_lo[0];
      b.min_y = box_lo[1];
      b.min_z = box_lo[2];
      b.max_x = box_hi[0];
      b.max_y = box_hi[1];
      b.max_z = box_hi[2];
      pending_boxes.push_back(b);
      clear_running_box();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic coord_t rand_coord();
    int mag;
    case ($urandom_range(0, 6))
      0: return COORD_MAX;
      1: return COORD_MIN;
      2: return '0;
      3, 4: return $urandom;
      default: begin
        // values within +/-256.0 so boxes stay unsaturated
        mag = $urandom_range(0, 1 << 24);
        return $urandom_range(0, 1) ? coord_t'(-mag) : coord_t'(mag);
      end
    endcase
  endfunction

  function automatic logic [tvbb_pkg::COEF_WIDTH-1:0] rand_coef(input int style);
    int mag;
    case (style)
      COEF_FULL: return $urandom;
      COEF_EXTREME: begin
        case ($urandom_range(0, 3))
          0: return '0;
          1: return Q_NEG_LSB;
          2: return Q_MIN;
          default: return Q_MAX;
        endcase
      end
      COEF_UNIT: begin
        case ($urandom_range(0, 2))
          0: return Q_NEG_ONE;
          1: return '0;
          default: return Q_ONE;
        endcase
      end
      default: begin
        mag = $urandom_range(0, 1 << 18);
        return $urandom_range(0, 1) ? -mag : mag;
      end
    endcase
  endfunction

  // Send one vertex: idle a random number of cycles, then hold the
  // transaction until it is taken. Valid stays high afterwards so that
  // back-to-back vertices follow without a gap.
  task automatic send_vertex(input coord_t x, input coord_t y, input coord_t z,
                             input logic last);
    int gap;
    gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata  = {z, y, x};
    in_tlast  = last;
    in_tvalid = 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    accumulate_vertex(x, y, z, last);
    vertices_sent++;
  endtask

  // Drop valid, wait for every queued box, then let the pipeline empty out
  // behind any trailing vertices that produce no box.
  task automatic settle_pipeline();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_boxes.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [tvbb_pkg::CFG_IDX_WIDTH-1:0] idx,
                           input logic [tvbb_pkg::CFG_WIDTH-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      tvbb_pkg::REG_ROW0_A: row_coef_a[0] = data;
      tvbb_pkg::REG_ROW0_B: row_coef_b[0] = data;
      tvbb_pkg::REG_ROW1_A: row_coef_a[1] = data;
      tvbb_pkg::REG_ROW1_B: row_coef_b[1] = data;
      tvbb_pkg::REG_ROW2_A: row_coef_a[2] = data;
      tvbb_pkg::REG_ROW2_B: row_coef_b[2] = data;
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic write_transform(input logic [tvbb_pkg::CFG_WIDTH-1:0] a0,
                                 input logic [tvbb_pkg::CFG_WIDTH-1:0] b0,
                                 input logic [tvbb_pkg::CFG_WIDTH-1:0] a1,
                                 input logic [tvbb_pkg::CFG_WIDTH-1:0] b1,
                                 input logic [tvbb_pkg::CFG_WIDTH-1:0] a2,
                                 input logic [tvbb_pkg::CFG_WIDTH-1:0] b2);
    settle_pipeline();
    write_reg(tvbb_pkg::REG_ROW0_A, a0);
    write_reg(tvbb_pkg::REG_ROW0_B, b0);
    write_reg(tvbb_pkg::REG_ROW1_A, a1);
    write_reg(tvbb_pkg::REG_ROW1_B, b1);
    write_reg(tvbb_pkg::REG_ROW2_A, a2);
    write_reg(tvbb_pkg::REG_ROW2_B, b2);
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS)
      $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  task automatic compare_field(input string name, input coord_t want, input coord_t got);
    if (want !== got)
      report_mismatch($sformatf("box %0d %s expected %h got %h",
                                boxes_checked, name, want, got));
  endtask

  // Receiver: draw a stall per box, then hold ready until a box is taken
  initial begin
    int stall;
    out_tready = 1'b0;
    wait (rst_n);
    forever begin
      stall = (stall_max == 0) ? 0 : $urandom_range(0, stall_max);
      @(negedge clk);
      if (stall > 0) begin
        out_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready = 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  // Compare every taken box with the oldest prediction
  always @(posedge clk) begin
    box_t got;
    box_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[6*CW-1:0];
      if (pending_boxes.size() == 0) begin
        report_mismatch($sformatf("box %h arrived with none expected", got));
      end else begin
        want = pending_boxes.pop_front();
        compare_field("min_x", want.min_x, got.min_x);
        compare_field("min_y", want.min_y, got.min_y);
        compare_field("min_z", want.min_z, got.min_z);
        compare_field("max_x", want.max_x, got.max_x);
        compare_field("max_y", want.max_y, got.max_y);
        compare_field("max_z", want.max_z, got.max_z);
      end
      boxes_checked++;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset transform is the identity; a single-vertex set returns that point
  task automatic test_identity_single();
    send_vertex(COORD_MAX, COORD_MIN, '0, 1'b1);
    send_vertex(-1, 1, 32'sh1234_5678, 1'b1);
  endtask

  // Half-LSB products: +0.5 LSB rounds up, -0.5 LSB rounds toward plus infinity
  task automatic test_rounding();
    write_transform({32'h0, Q_LSB}, '0,
                    {Q_NEG_LSB, 32'h0}, {Q_LSB, 32'h0},
                    '0, {32'h0, Q_LSB});
    send_vertex(32'sd32768, 32'sd32768, 32'sd32768, 1'b1);
    send_vertex(-32'sd32768, -32'sd32768, -32'sd32768, 1'b1);
    send_vertex(32'sd32767, -32'sd32769, 32'sd98304, 1'b0);
    send_vertex(-32'sd98304, 32'sd0, -32'sd32767, 1'b1);
  endtask

  // Largest coefficients and translations drive every axis into the clamp
  task automatic test_saturation();
    write_transform({Q_MAX, Q_MAX}, {Q_MAX, Q_MAX},
                    {Q_MIN, Q_MIN}, {Q_MIN, Q_MIN},
                    {32'h0, Q_MIN}, {Q_MAX, 32'h0});
    send_vertex(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1);
    send_vertex(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1);
    send_vertex(COORD_MIN, COORD_MAX, '0, 1'b0);
    send_vertex(COORD_MAX, COORD_MIN, '0, 1'b1);
  endtask

  // Writes past the last register must leave the transform untouched
  task automatic test_spare_index();
    write_transform(tvbb_pkg::ROW0_A_RST, tvbb_pkg::ROW0_B_RST,
                    tvbb_pkg::ROW1_A_RST, tvbb_pkg::ROW1_B_RST,
                    tvbb_pkg::ROW2_A_RST, tvbb_pkg::ROW2_B_RST);
    write_reg(REG_SPARE_LO, '1);
    write_reg(REG_SPARE_HI, '1);
    send_vertex(32'sh0001_8000, -32'sh0002_0000, 32'sh0000_0001, 1'b1);
    send_vertex(-1, -1, -1, 1'b1);
  endtask

  // Multi-vertex sets with no idling on either side, then with backpressure
  task automatic test_multi_vertex();
    write_transform({Q_NEG_ONE, Q_ONE}, {Q_ONE, 32'h0003_0000},
                    {Q_ONE, Q_ONE}, {Q_NEG_ONE, Q_NEG_ONE},
                    {32'h0, Q_NEG_ONE}, {Q_ONE, 32'h0000_8000});
    gap_max   = 0;
    stall_max = 0;
    send_vertex(32'sh0010_0000, -32'sh0004_0000, 32'sh0000_1000, 1'b0);
    send_vertex(-32'sh0020_0000, 32'sh0001_0000, COORD_MAX, 1'b0);
    send_vertex(COORD_MIN, 32'sh0000_0000, -32'sh0001_0000, 1'b1);
    stall_max = MAX_IDLE;
    send_vertex(32'sh0000_0001, 32'sh0000_0002, 32'sh0000_0003, 1'b0);
    send_vertex(-32'sh0000_0003, -32'sh0000_0002, -32'sh0000_0001, 1'b1);
    gap_max   = MAX_IDLE;
  endtask

  // Random sets under a new transform in each phase; the idle settings rotate
  // so some phases run with no gaps on one or both sides.
  task automatic test_random_sets();
    int items;
    int set_len;
    int style;
    for (int phase = 0; phase < PHASES; phase++) begin
      style = phase % 4;
      settle_pipeline();
      gap_max   = (phase % 3 == 2) ? 0 : MAX_IDLE;
      stall_max = (phase % 4 == 1) ? 0 : MAX_IDLE;
      write_reg(tvbb_pkg::REG_ROW0_A, {rand_coef(style), rand_coef(style)});
      write_reg(tvbb_pkg::REG_ROW0_B, {rand_coef(style), rand_coef(style)});
      write_reg(tvbb_pkg::REG_ROW1_A, {rand_coef(style), rand_coef(style)});
      write_reg(tvbb_pkg::REG_ROW1_B, {rand_coef(style), rand_coef(style)});
      write_reg(tvbb_pkg::REG_ROW2_A, {rand_coef(style), rand_coef(style)});
      write_reg(tvbb_pkg::REG_ROW2_B, {rand_coef(style), rand_coef(style)});
      if (phase % 2 == 1)
        write_reg(phase % 4 == 1 ? REG_SPARE_LO : REG_SPARE_HI, {$urandom, $urandom});
      items = 0;
      while (items < PHASE_ITEMS) begin
        set_len = $urandom_range(1, MAX_SET_LEN);
        for (int k = 0; k < set_len; k++)
          send_vertex(rand_coord(), rand_coord(), rand_coord(), k == set_len - 1);
        items += set_len;
      end
    end
    gap_max   = MAX_IDLE;
    stall_max = MAX_IDLE;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n     = 1'b0;
    in_tdata  = '0;
    in_tlast  = 1'b0;
    in_tvalid = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    load_identity();
    clear_running_box();
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    test_identity_single();
    test_rounding();
    test_saturation();
    test_spare_index();
    test_multi_vertex();
    test_random_sets();

    // Let the last boxes drain before judging
    settle_pipeline();

    $display("Covered %0d vertices and %0d boxes across %0d register writes.",
             vertices_sent, boxes_checked, reg_writes);
    $display("Transforms: identity, half-LSB rounding, clamping, moderate, full, extreme, unit.");
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run
  initial begin
    #5_000_000;
    $display("Timeout: %0d boxes still outstanding", pending_boxes.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

@@ files.f @@
hdl/tvbb_pkg.sv
hdl/tvbb_row.sv
hdl/transformed_vertex_bounding_box_top.sv
tb/sv/transformed_vertex_bounding_box_top_test.sv
